// ===== rtl/core/rectangle_overlap_clip_subtract_unit_macros.svh =====
// Assertion macros shared by the rectangle overlap, clip and subtract unit.
`ifndef RECTANGLE_OVERLAP_CLIP_SUBTRACT_UNIT_MACROS_SVH
`define RECTANGLE_OVERLAP_CLIP_SUBTRACT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ROCSU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rocsu assertion failed");
// next-cycle implication
`define ROCSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rocsu assertion failed");
`else
`define ROCSU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ROCSU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/rocsu_pkg.sv =====
// Shared constants and types of the rectangle overlap, clip and subtract unit.
package rocsu_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEFAULT = 16;

   // pieces one item can produce
   localparam int PIECE_MAX = 4;
   localparam int PIECE_IDX_BITS = $clog2(PIECE_MAX);

   // operation codes
   localparam logic [1:0] MODE_OVERLAP   = 2'd0;
   localparam logic [1:0] MODE_INTERSECT = 2'd1;
   localparam logic [1:0] MODE_SUBTRACT  = 2'd2;

   // piece slots, in output order
   localparam int PC_LEFT   = 0;
   localparam int PC_TOP    = 1;
   localparam int PC_RIGHT  = 2;
   localparam int PC_BOTTOM = 3;

   // which pieces exist and their found flags
   typedef struct packed {
      logic [PIECE_MAX-1:0] mask;
      logic [PIECE_MAX-1:0] found;
   } piece_ctl_type;

endpackage

// ===== rtl/core/rocsu_channels.sv =====
// Request and response channel interfaces of the rectangle unit.
interface rocsu_req_if #(
   parameter int COORD_BITS = rocsu_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode;
   logic signed [COORD_BITS-1:0] a_left;
   logic signed [COORD_BITS-1:0] a_top;
   logic signed [COORD_BITS-1:0] a_right;
   logic signed [COORD_BITS-1:0] a_bottom;
   logic signed [COORD_BITS-1:0] b_left;
   logic signed [COORD_BITS-1:0] b_top;
   logic signed [COORD_BITS-1:0] b_right;
   logic signed [COORD_BITS-1:0] b_bottom;

   modport source (
      output valid, mode, a_left, a_top, a_right, a_bottom,
             b_left, b_top, b_right, b_bottom,
      input  ready
   );
   modport sink (
      input  valid, mode, a_left, a_top, a_right, a_bottom,
             b_left, b_top, b_right, b_bottom,
      output ready
   );
endinterface

interface rocsu_rsp_if #(
   parameter int COORD_BITS = rocsu_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_left;
   logic signed [COORD_BITS-1:0] out_top;
   logic signed [COORD_BITS-1:0] out_right;
   logic signed [COORD_BITS-1:0] out_bottom;
   logic                         found;
   logic                         last;

   modport source (
      output valid, out_left, out_top, out_right, out_bottom, found, last,
      input  ready
   );
   modport sink (
      input  valid, out_left, out_top, out_right, out_bottom, found, last,
      output ready
   );
endinterface

// ===== rtl/core/rocsu_calc.sv =====
// Combinational overlap test, clip and four-way split of one rectangle pair.
module rocsu_calc #(
   parameter int COORD_BITS = rocsu_pkg::COORD_BITS_DEFAULT
) (
   input  logic [1:0]                                        mode,
   input  logic signed [COORD_BITS-1:0]                      a_left,
   input  logic signed [COORD_BITS-1:0]                      a_top,
   input  logic signed [COORD_BITS-1:0]                      a_right,
   input  logic signed [COORD_BITS-1:0]                      a_bottom,
   input  logic signed [COORD_BITS-1:0]                      b_left,
   input  logic signed [COORD_BITS-1:0]                      b_top,
   input  logic signed [COORD_BITS-1:0]                      b_right,
   input  logic signed [COORD_BITS-1:0]                      b_bottom,
   output logic [rocsu_pkg::PIECE_MAX-1:0][COORD_BITS-1:0]   pc_left,
   output logic [rocsu_pkg::PIECE_MAX-1:0][COORD_BITS-1:0]   pc_top,
   output logic [rocsu_pkg::PIECE_MAX-1:0][COORD_BITS-1:0]   pc_right,
   output logic [rocsu_pkg::PIECE_MAX-1:0][COORD_BITS-1:0]   pc_bottom,
   output rocsu_pkg::piece_ctl_type                          pc_ctl
);

   logic                         overlap;
   logic signed [COORD_BITS-1:0] max_left;
   logic signed [COORD_BITS-1:0] max_top;
   logic signed [COORD_BITS-1:0] min_right;
   logic signed [COORD_BITS-1:0] min_bottom;
   logic [rocsu_pkg::PIECE_MAX-1:0] split;

   // overlap and clipped edges
   assign overlap = !(a_left > b_right || a_right < b_left ||
                      a_top > b_bottom || a_bottom < b_top);
   assign max_left   = (a_left > b_left)     ? a_left   : b_left;
   assign max_top    = (a_top > b_top)       ? a_top    : b_top;
   assign min_right  = (a_right < b_right)   ? a_right  : b_right;
   assign min_bottom = (a_bottom < b_bottom) ? a_bottom : b_bottom;

   // which difference pieces qualify
   always_comb begin
      split = '0;
      split[rocsu_pkg::PC_LEFT]   = (b_left > a_left) && (a_bottom >= a_top);
      split[rocsu_pkg::PC_TOP]    = (b_right >= b_left) && (b_top > a_top);
      split[rocsu_pkg::PC_RIGHT]  = (a_right > b_right) && (a_bottom >= a_top);
      split[rocsu_pkg::PC_BOTTOM] = (b_right >= b_left) && (a_bottom > b_bottom);
   end

   // piece list; slot zero echoes A unless overwritten
   always_comb begin
      for (int i = 0; i < rocsu_pkg::PIECE_MAX; i++) begin
         pc_left[i]   = a_left;
         pc_top[i]    = a_top;
         pc_right[i]  = a_right;
         pc_bottom[i] = a_bottom;
      end
      pc_ctl.mask  = {{(rocsu_pkg::PIECE_MAX-1){1'b0}}, 1'b1};
      pc_ctl.found = '0;
      unique case (mode)
         rocsu_pkg::MODE_OVERLAP: begin
            pc_ctl.found[0] = overlap;
         end
         rocsu_pkg::MODE_INTERSECT: begin
            if (overlap) begin
               pc_left[0]      = max_left;
               pc_top[0]       = max_top;
               pc_right[0]     = min_right;
               pc_bottom[0]    = min_bottom;
               pc_ctl.found[0] = (min_right >= max_left) && (min_bottom >= max_top);
            end
         end
         rocsu_pkg::MODE_SUBTRACT: begin
            if (!overlap) begin
               pc_ctl.found[0] = 1'b1;
            end else if (split != '0) begin
               pc_ctl.mask  = split;
               pc_ctl.found = split;
               // left strip
               pc_right[rocsu_pkg::PC_LEFT]   = b_left - COORD_BITS'(1);
               // top strip
               pc_left[rocsu_pkg::PC_TOP]     = max_left;
               pc_right[rocsu_pkg::PC_TOP]    = min_right;
               pc_bottom[rocsu_pkg::PC_TOP]   = b_top - COORD_BITS'(1);
               // right strip
               pc_left[rocsu_pkg::PC_RIGHT]   = b_right + COORD_BITS'(1);
               // bottom strip
               pc_left[rocsu_pkg::PC_BOTTOM]  = max_left;
               pc_top[rocsu_pkg::PC_BOTTOM]   = b_bottom + COORD_BITS'(1);
               pc_right[rocsu_pkg::PC_BOTTOM] = min_right;
            end
         end
         default: begin
            // unused code: echo A, not found
            pc_ctl.found = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/rectangle_overlap_clip_subtract_unit.sv =====
// Top level of the rectangle overlap test, clip and subtract unit.
//
// Usage: each item on req_chan carries a mode and rectangles A and B with
// inclusive signed edges. Mode 0 tests overlap, mode 1 clips A to B, mode 2
// splits A minus B into up to four pieces (left, top, right, bottom). Every
// item yields one to four rsp_chan items; last marks the final one.
// Both channels move an item on a clock edge with valid and ready high.
// An accepted item waits in the stage register; its first result then moves
// on to the output register once that register is free.
// Throughput: one cycle per result while the receiver does not stall. Items
// with one result go back to back; a subtract with n pieces holds the stage
// register until all n have left, since that register hands out one piece
// per cycle to the output register. A new item is taken in the same cycle
// the last piece of the previous one moves on. When the receiver stalls,
// the output register holds its item and the stage register waits behind it.
// Reset (synchronous, active high) empties both registers.
`include "rectangle_overlap_clip_subtract_unit_macros.svh"

module rectangle_overlap_clip_subtract_unit #(
   parameter int COORD_BITS = rocsu_pkg::COORD_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   rocsu_req_if.sink   req_chan,
   rocsu_rsp_if.source rsp_chan
);

   localparam int PN = rocsu_pkg::PIECE_MAX;
   localparam int PI = rocsu_pkg::PIECE_IDX_BITS;

   // stage register
   logic                         s1_valid_ff, s1_valid_in;
   logic [PN-1:0]                sent_ff, sent_in;
   logic [1:0]                   s1_mode_ff;
   logic signed [COORD_BITS-1:0] s1_a_left_ff, s1_a_top_ff, s1_a_right_ff, s1_a_bottom_ff;
   logic signed [COORD_BITS-1:0] s1_b_left_ff, s1_b_top_ff, s1_b_right_ff, s1_b_bottom_ff;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] out_left_ff, out_top_ff, out_right_ff, out_bottom_ff;
   logic                         found_ff, last_ff;

   // piece list
   logic [PN-1:0][COORD_BITS-1:0] pc_left, pc_top, pc_right, pc_bottom;
   rocsu_pkg::piece_ctl_type      pc_ctl;

   // piece selection
   logic [PN-1:0] pend;
   logic [PI-1:0] sel_idx;
   logic [PN-1:0] sel_onehot;
   logic          sel_last;
   logic          out_free;
   logic          adv;
   logic          req_take;

   rocsu_calc #(
      .COORD_BITS (COORD_BITS)
   ) u_calc (
      .mode      (s1_mode_ff),
      .a_left    (s1_a_left_ff),
      .a_top     (s1_a_top_ff),
      .a_right   (s1_a_right_ff),
      .a_bottom  (s1_a_bottom_ff),
      .b_left    (s1_b_left_ff),
      .b_top     (s1_b_top_ff),
      .b_right   (s1_b_right_ff),
      .b_bottom  (s1_b_bottom_ff),
      .pc_left   (pc_left),
      .pc_top    (pc_top),
      .pc_right  (pc_right),
      .pc_bottom (pc_bottom),
      .pc_ctl    (pc_ctl)
   );

   // lowest pending piece goes next
   assign pend = pc_ctl.mask & ~sent_ff;
   always_comb begin
      sel_idx = '0;
      for (int i = PN - 1; i >= 0; i--) begin
         if (pend[i]) begin
            sel_idx = PI'(i);
         end
      end
   end
   assign sel_onehot = PN'(1) << sel_idx;
   assign sel_last   = (pend & ~sel_onehot) == '0;

   // handshakes
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign adv            = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || (out_free && sel_last);
   assign req_take       = req_chan.valid && req_chan.ready;

   // stage control next state
   always_comb begin
      s1_valid_in = s1_valid_ff;
      sent_in     = sent_ff;
      if (adv && !sel_last) begin
         sent_in = sent_ff | sel_onehot;
      end
      if (adv && sel_last) begin
         s1_valid_in = 1'b0;
         sent_in     = '0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         sent_in     = '0;
      end
   end

   // output valid next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = adv;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff     <= req_chan.mode;
         s1_a_left_ff   <= req_chan.a_left;
         s1_a_top_ff    <= req_chan.a_top;
         s1_a_right_ff  <= req_chan.a_right;
         s1_a_bottom_ff <= req_chan.a_bottom;
         s1_b_left_ff   <= req_chan.b_left;
         s1_b_top_ff    <= req_chan.b_top;
         s1_b_right_ff  <= req_chan.b_right;
         s1_b_bottom_ff <= req_chan.b_bottom;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (adv) begin
         out_left_ff   <= pc_left[sel_idx];
         out_top_ff    <= pc_top[sel_idx];
         out_right_ff  <= pc_right[sel_idx];
         out_bottom_ff <= pc_bottom[sel_idx];
         found_ff      <= pc_ctl.found[sel_idx];
         last_ff       <= sel_last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_left   = out_left_ff;
   assign rsp_chan.out_top    = out_top_ff;
   assign rsp_chan.out_right  = out_right_ff;
   assign rsp_chan.out_bottom = out_bottom_ff;
   assign rsp_chan.found      = found_ff;
   assign rsp_chan.last       = last_ff;

   // a held item always has a piece left to send
   `ROCSU_ASSERT_IMP(a_pend_nonzero, clock, reset, s1_valid_ff, pend != '0)
   // sent pieces are a subset of the piece list
   `ROCSU_ASSERT_IMP(a_sent_subset, clock, reset, s1_valid_ff, (sent_ff & ~pc_ctl.mask) == '0)
   // an item stays in the stage until its last piece moves
   `ROCSU_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !(adv && sel_last), s1_valid_ff)
   // a result without found is always the only one of its item
   `ROCSU_ASSERT_IMP(a_notfound_last, clock, reset, rsp_valid_ff && !found_ff, last_ff)

endmodule
